/* rtl/core/prt_pkg.sv */
// Shared types, register codes and helpers for the point rigid transform.
package prt_pkg;

	// Field and arithmetic widths
	localparam int COORD_W   = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 32;
	localparam int PROD_W    = 62;  // product of two clamped Q2.30 components
	localparam int MAT_W     = 34;  // matrix entry, Q2.30 with headroom

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_W  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_X  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z = 3'd6;

	// Fixed-point constants
	localparam logic signed [31:0] QONE     = 32'sh4000_0000;  // +1.0 in Q2.30
	localparam logic signed [31:0] QNEG     = 32'shC000_0000;  // -1.0 in Q2.30
	localparam logic signed [31:0] OUT_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] OUT_MIN  = 32'sh8000_0000;
	localparam logic signed [63:0] HALF_Q30 = 64'sd536870912;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic        [COORD_W-1:0] point_level;
	} point_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic signed [COORD_W-1:0] out_z;
		logic        [COORD_W-1:0] out_level;
	} result_t;

	// Limit a quaternion component to [-1.0, 1.0]
	function automatic logic signed [31:0] clamp_quat(input logic signed [31:0] v);
		logic signed [31:0] r;
		r = v;
		if (v > QONE) begin
			r = QONE;
		end else if (v < QNEG) begin
			r = QNEG;
		end
		return r;
	endfunction

	// Round 2*s (s in Q4.60) to Q2.30, floor after adding one half
	function automatic logic signed [MAT_W-1:0] twice_q30(input logic signed [PROD_W:0] s);
		logic signed [63:0] v;
		v = (64'(s) <<< 1) + HALF_Q30;
		return MAT_W'(v >>> 30);
	endfunction

endpackage

/* rtl/core/point_rigid_transform_top.sv */
// Point rigid transform: quaternion rotation plus translation, Q16.16 points.
//
//  channel   | handshake          | payload              | notes
//  ----------+--------------------+----------------------+---------------------------
//  request   | start, busy        | point   (point_t)    | taken when start & !busy
//  result    | done               | result  (result_t)   | one-cycle strobe, no hold
//  config    | cfg_we, cfg_index  | cfg_data (32 bits)   | write only, indexes 0..6
//
// One point per cycle unless busy; done strobes each result at the end of the
// point pipeline. The rotation matrix is rebuilt from the quaternion registers
// after a write, ahead of the matrix-multiply stage of any point taken after the
// write. Reset (arst_n low) loads the identity rotation and zero translation;
// busy is high in reset and until its register is clocked after it, low otherwise.
// Nothing stalls: the receiver takes every result on its strobe cycle.
module point_rigid_transform_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  prt_pkg::point_t                  point,
	output logic                             done,
	output prt_pkg::result_t                 result,
	input  logic                             cfg_we,
	input  logic [prt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [prt_pkg::CFG_W-1:0]        cfg_data
);

	localparam int MW = prt_pkg::MAT_W;
	localparam int PW = prt_pkg::PROD_W;

	// Configuration registers
	logic signed [31:0] quat_w_q, quat_x_q, quat_y_q, quat_z_q;
	logic signed [31:0] shift_q [3];
	logic               busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_w_q <= prt_pkg::QONE;
			quat_x_q <= '0;
			quat_y_q <= '0;
			quat_z_q <= '0;
			for (int i = 0; i < 3; i++) begin
				shift_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				prt_pkg::REG_QUAT_W:  quat_w_q   <= cfg_data;
				prt_pkg::REG_QUAT_X:  quat_x_q   <= cfg_data;
				prt_pkg::REG_QUAT_Y:  quat_y_q   <= cfg_data;
				prt_pkg::REG_QUAT_Z:  quat_z_q   <= cfg_data;
				prt_pkg::REG_SHIFT_X: shift_q[0] <= cfg_data;
				prt_pkg::REG_SHIFT_Y: shift_q[1] <= cfg_data;
				prt_pkg::REG_SHIFT_Z: shift_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Ready after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;

	// Matrix build, step 1: quaternion products
	logic signed [31:0]   qw, qx, qy, qz;
	logic signed [PW-1:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, xw_q, yw_q, zw_q;

	assign qw = prt_pkg::clamp_quat(quat_w_q);
	assign qx = prt_pkg::clamp_quat(quat_x_q);
	assign qy = prt_pkg::clamp_quat(quat_y_q);
	assign qz = prt_pkg::clamp_quat(quat_z_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xx_q <= '0; yy_q <= '0; zz_q <= '0;
			xy_q <= '0; xz_q <= '0; yz_q <= '0;
			xw_q <= '0; yw_q <= '0; zw_q <= '0;
		end else begin
			xx_q <= PW'(qx) * PW'(qx);
			yy_q <= PW'(qy) * PW'(qy);
			zz_q <= PW'(qz) * PW'(qz);
			xy_q <= PW'(qx) * PW'(qy);
			xz_q <= PW'(qx) * PW'(qz);
			yz_q <= PW'(qy) * PW'(qz);
			xw_q <= PW'(qx) * PW'(qw);
			yw_q <= PW'(qy) * PW'(qw);
			zw_q <= PW'(qz) * PW'(qw);
		end
	end

	// Matrix build, step 2: rounded entries, row-major
	logic signed [MW-1:0] mat_q [9];
	logic signed [MW-1:0] one_m;

	assign one_m = MW'(prt_pkg::QONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// identity: ones on the diagonal
			for (int i = 0; i < 9; i++) begin
				mat_q[i] <= (i == 0 || i == 4 || i == 8) ? MW'(prt_pkg::QONE) : '0;
			end
		end else begin
			mat_q[0] <= one_m - prt_pkg::twice_q30((PW+1)'(yy_q) + (PW+1)'(zz_q));
			mat_q[1] <= prt_pkg::twice_q30((PW+1)'(xy_q) - (PW+1)'(zw_q));
			mat_q[2] <= prt_pkg::twice_q30((PW+1)'(xz_q) + (PW+1)'(yw_q));
			mat_q[3] <= prt_pkg::twice_q30((PW+1)'(xy_q) + (PW+1)'(zw_q));
			mat_q[4] <= one_m - prt_pkg::twice_q30((PW+1)'(xx_q) + (PW+1)'(zz_q));
			mat_q[5] <= prt_pkg::twice_q30((PW+1)'(yz_q) - (PW+1)'(xw_q));
			mat_q[6] <= prt_pkg::twice_q30((PW+1)'(xz_q) - (PW+1)'(yw_q));
			mat_q[7] <= prt_pkg::twice_q30((PW+1)'(yz_q) + (PW+1)'(xw_q));
			mat_q[8] <= one_m - prt_pkg::twice_q30((PW+1)'(xx_q) + (PW+1)'(yy_q));
		end
	end

	// Valid bits along the point pipeline
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= start && !busy_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	assign done = v_s6;

	// Stage 1: request capture
	prt_pkg::point_t pt_s1;

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			pt_s1 <= point;
		end
	end

	// Stage 2: split coordinates into signed high and unsigned low halves
	logic signed [31:0] p_c [3];
	logic signed [15:0] ph_s2 [3];
	logic        [15:0] pl_s2 [3];
	logic        [31:0] lvl_s2, lvl_s3, lvl_s4, lvl_s5;

	assign p_c[0] = pt_s1.point_x;
	assign p_c[1] = pt_s1.point_y;
	assign p_c[2] = pt_s1.point_z;

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			ph_s2[c] <= p_c[c][31:16];
			pl_s2[c] <= p_c[c][15:0];
		end
		lvl_s2 <= pt_s1.point_level;
	end

	// Stage 3: partial products, matrix entry times each coordinate half
	logic signed [MW+15:0] hi_p_s3 [9];
	logic signed [MW+16:0] lo_p_s3 [9];

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				hi_p_s3[r*3+c] <= (MW+16)'(mat_q[r*3+c]) * (MW+16)'(ph_s2[c]);
				lo_p_s3[r*3+c] <= (MW+17)'(mat_q[r*3+c])
					* (MW+17)'($signed({1'b0, pl_s2[c]}));
			end
		end
		lvl_s3 <= lvl_s2;
	end

	// Stage 4: row sums of the high and low partial products
	logic signed [MW+17:0] hi_s4 [3];
	logic signed [MW+18:0] lo_s4 [3];

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			hi_s4[r] <= (MW+18)'(hi_p_s3[r*3]) + (MW+18)'(hi_p_s3[r*3+1])
				+ (MW+18)'(hi_p_s3[r*3+2]);
			lo_s4[r] <= (MW+19)'(lo_p_s3[r*3]) + (MW+19)'(lo_p_s3[r*3+1])
				+ (MW+19)'(lo_p_s3[r*3+2]);
		end
		lvl_s4 <= lvl_s3;
	end

	// Stage 5: round the exact sum to Q16.16
	logic signed [MW+3:0]  hh_c  [3];
	logic signed [MW+19:0] t_c   [3];
	logic signed [MW+4:0]  rnd_c [3];
	logic signed [MW+4:0]  rnd_s5 [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			hh_c[r]  = (MW+4)'(hi_s4[r] >>> 14);
			t_c[r]   = (MW+20)'($signed({1'b0, hi_s4[r][13:0], 16'b0}))
				+ (MW+20)'(lo_s4[r]) + (MW+20)'(prt_pkg::HALF_Q30);
			rnd_c[r] = (MW+5)'(hh_c[r]) + (MW+5)'(t_c[r] >>> 30);
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			rnd_s5[r] <= rnd_c[r];
		end
		lvl_s5 <= lvl_s4;
	end

	// Stage 6: add translation, saturate, drive the result
	logic signed [MW+5:0] sum_c [3];
	logic signed [31:0]   sat_c [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum_c[r] = (MW+6)'(rnd_s5[r]) + (MW+6)'(shift_q[r]);
			if (sum_c[r] > (MW+6)'(prt_pkg::OUT_MAX)) begin
				sat_c[r] = prt_pkg::OUT_MAX;
			end else if (sum_c[r] < (MW+6)'(prt_pkg::OUT_MIN)) begin
				sat_c[r] = prt_pkg::OUT_MIN;
			end else begin
				sat_c[r] = sum_c[r][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s5) begin
			result.out_x     <= sat_c[0];
			result.out_y     <= sat_c[1];
			result.out_z     <= sat_c[2];
			result.out_level <= lvl_s5;
		end
	end

	// Every accepted request yields a result strobe on done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##6 done)
		else $error("request without result");

	// No result without a request
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 6))
		else $error("result without request");

	// Level word carried through unchanged
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.out_level == $past(point.point_level, 6)))
		else $error("level word corrupted");

	// Ready after reset, once arst_n was already high at the last sample
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> !busy)
		else $error("busy outside reset");

endmodule

/* dv/point_rigid_transform_checker.sv */
// Checker for the point rigid transform: predicts each moved point and compares results.
module point_rigid_transform_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  prt_pkg::point_t               point,
	input  logic                          done,
	input  prt_pkg::result_t              result,
	input  logic                          cfg_we,
	input  logic [prt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [prt_pkg::CFG_W-1:0]     cfg_data,
	output int                            fail_count,
	output int                            pending,
	output int                            checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint UNIT = prt_pkg::QONE;

	// Local copy of the pose registers, same indexes as the block
	logic signed [31:0] pose_reg [0:6];

	// Moved points still owed by the block, oldest first
	prt_pkg::result_t owed_points [$];

	// Quaternion component limited to [-1.0, 1.0]
	function automatic longint clamp_unit(input logic signed [31:0] v);
		longint c;
		c = v;
		if (c > UNIT) begin
			c = UNIT;
		end else if (c < -UNIT) begin
			c = -UNIT;
		end
		return c;
	endfunction

	// 2*s with s in Q4.60, rounded half up to Q2.30
	function automatic longint twice_rounded(input longint s);
		return (2 * s + prt_pkg::HALF_Q30) >>> 30;
	endfunction

	// Rotate by the configured quaternion, translate, saturate
	function automatic prt_pkg::result_t move_point(input prt_pkg::point_t p);
		longint qw, qx, qy, qz;
		longint rot [0:2][0:2];
		logic signed [127:0] coord [0:2];
		logic signed [127:0] acc, term;
		logic [31:0] moved [0:2];
		prt_pkg::result_t r;
		int i, j;
		qw = clamp_unit(pose_reg[prt_pkg::REG_QUAT_W]);
		qx = clamp_unit(pose_reg[prt_pkg::REG_QUAT_X]);
		qy = clamp_unit(pose_reg[prt_pkg::REG_QUAT_Y]);
		qz = clamp_unit(pose_reg[prt_pkg::REG_QUAT_Z]);
		rot[0][0] = UNIT - twice_rounded(qy * qy + qz * qz);
		rot[0][1] = twice_rounded(qx * qy - qz * qw);
		rot[0][2] = twice_rounded(qx * qz + qy * qw);
		rot[1][0] = twice_rounded(qx * qy + qz * qw);
		rot[1][1] = UNIT - twice_rounded(qx * qx + qz * qz);
		rot[1][2] = twice_rounded(qy * qz - qx * qw);
		rot[2][0] = twice_rounded(qx * qz - qy * qw);
		rot[2][1] = twice_rounded(qy * qz + qx * qw);
		rot[2][2] = UNIT - twice_rounded(qx * qx + qy * qy);
		coord[0] = $signed(p.point_x);
		coord[1] = $signed(p.point_y);
		coord[2] = $signed(p.point_z);
		for (i = 0; i < 3; i++) begin
			// exact Q18.46 dot product, then round to Q16.16
			acc = 0;
			for (j = 0; j < 3; j++) begin
				term = rot[i][j];
				acc = acc + term * coord[j];
			end
			acc = ((acc + prt_pkg::HALF_Q30) >>> 30) + pose_reg[prt_pkg::REG_SHIFT_X + i];
			if (acc > prt_pkg::OUT_MAX) begin
				acc = prt_pkg::OUT_MAX;
			end else if (acc < prt_pkg::OUT_MIN) begin
				acc = prt_pkg::OUT_MIN;
			end
			moved[i] = acc[31:0];
		end
		r.out_x = moved[0];
		r.out_y = moved[1];
		r.out_z = moved[2];
		r.out_level = p.point_level;
		return r;
	endfunction

	function automatic bit field_ok(input string tag, input logic [31:0] want,
			input logic [31:0] got);
		if (got === want) begin
			return 1'b1;
		end
		$display("%0t ns: %s mismatch, expected %h, got %h", $time, tag, want, got);
		return 1'b0;
	endfunction

	// Track register writes, queue predictions, compare results
	always @(posedge clk or negedge arst_n) begin : watch
		prt_pkg::result_t want;
		bit ok;
		if (!arst_n) begin
			pose_reg[prt_pkg::REG_QUAT_W]  <= prt_pkg::QONE;
			pose_reg[prt_pkg::REG_QUAT_X]  <= '0;
			pose_reg[prt_pkg::REG_QUAT_Y]  <= '0;
			pose_reg[prt_pkg::REG_QUAT_Z]  <= '0;
			pose_reg[prt_pkg::REG_SHIFT_X] <= '0;
			pose_reg[prt_pkg::REG_SHIFT_Y] <= '0;
			pose_reg[prt_pkg::REG_SHIFT_Z] <= '0;
			owed_points.delete();
			fail_count = 0;
			checked = 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (owed_points.size() == 0) begin
					$display("%0t ns: result with none expected, expected nothing, got %p",
						$time, result);
					fail_count++;
				end else begin
					want = owed_points.pop_front();
					ok = field_ok("out_x", want.out_x, result.out_x)
						& field_ok("out_y", want.out_y, result.out_y)
						& field_ok("out_z", want.out_z, result.out_z)
						& field_ok("out_level", want.out_level, result.out_level);
					if (!ok) begin
						fail_count++;
					end
					checked++;
				end
			end
			if (start && !busy) begin
				owed_points = {owed_points, move_point(point)};
			end
			// indexes past the register list are dropped by the block
			if (cfg_we) begin
				case (cfg_index)
					prt_pkg::REG_QUAT_W, prt_pkg::REG_QUAT_X, prt_pkg::REG_QUAT_Y,
					prt_pkg::REG_QUAT_Z, prt_pkg::REG_SHIFT_X, prt_pkg::REG_SHIFT_Y,
					prt_pkg::REG_SHIFT_Z: begin
						pose_reg[cfg_index] <= cfg_data;
					end
					default: begin
					end
				endcase
			end
			pending <= owed_points.size();
		end
	end

endmodule

/* dv/point_rigid_transform_top_tb.sv */
// Testbench top for the point rigid transform: clock, reset, stimulus and verdict.
module point_rigid_transform_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_DEPTH = 6;
	localparam int SEGMENTS = 14;
	localparam int SEG_ITEMS = 100;
	localparam logic [31:0] QUARTER = 32'h2D41_3CCD;  // sqrt(0.5) in Q2.30
	localparam logic [prt_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	prt_pkg::point_t               point = '0;
	logic                          done;
	prt_pkg::result_t              result;
	logic                          cfg_we = 1'b0;
	logic [prt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [prt_pkg::CFG_W-1:0]     cfg_data = '0;

	int fail_count;
	int pending;
	int checked;
	int points_sent = 0;
	int poses = 0;
	int idle_pct = 0;

	point_rigid_transform_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.point(point),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	point_rigid_transform_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.point(point),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending),
		.checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hold request until the block takes it
	task automatic push_point(input logic [31:0] x, y, z, level);
		start <= 1'b1;
		point <= '{x, y, z, level};
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		points_sent++;
	endtask

	// Stop sending and let every owed result come back
	task automatic drain();
		start <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending != 0);
		repeat (PIPE_DEPTH) @(posedge clk);
	endtask

	task automatic write_reg(input logic [prt_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// Full pose load, with a stray write to the unused index first
	task automatic set_pose(input logic [31:0] qw, qx, qy, qz, sx, sy, sz);
		write_reg(REG_SPARE, $urandom);
		write_reg(prt_pkg::REG_QUAT_W, qw);
		write_reg(prt_pkg::REG_QUAT_X, qx);
		write_reg(prt_pkg::REG_QUAT_Y, qy);
		write_reg(prt_pkg::REG_QUAT_Z, qz);
		write_reg(prt_pkg::REG_SHIFT_X, sx);
		write_reg(prt_pkg::REG_SHIFT_Y, sy);
		write_reg(prt_pkg::REG_SHIFT_Z, sz);
		cfg_we <= 1'b0;
		poses++;
	endtask

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return $urandom;
			5, 6, 7: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
			8: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return $urandom_range(0, 32'h0001_FFFF) - 32'h0001_0000;
		endcase
	endfunction

	// Random pose: unit, in-range, raw 32-bit, or one or two nonzero components of +-1.0 or +-sqrt(0.5)
	task automatic random_pose();
		logic [31:0] q [0:3];
		logic [31:0] sh [0:2];
		real c [0:3];
		real norm;
		int pick, k;
		case ($urandom_range(0, 3))
			0: begin
				norm = 0.0;
				for (k = 0; k < 4; k++) begin
					c[k] = real'(int'($urandom_range(0, 2000)) - 1000);
					norm = norm + c[k] * c[k];
				end
				if (norm < 1.0) begin
					c[0] = 1.0;
					norm = 1.0;
				end
				norm = $sqrt(norm);
				for (k = 0; k < 4; k++) begin
					q[k] = $rtoi(c[k] / norm * 1073741824.0);
				end
			end
			1: begin
				for (k = 0; k < 4; k++) begin
					q[k] = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
				end
			end
			2: begin
				for (k = 0; k < 4; k++) begin
					q[k] = $urandom;
				end
			end
			default: begin
				for (k = 0; k < 4; k++) begin
					q[k] = '0;
				end
				pick = $urandom_range(0, 3);
				if ($urandom_range(0, 1)) begin
					q[pick] = $urandom_range(0, 1) ? prt_pkg::QONE : prt_pkg::QNEG;
				end else begin
					q[pick] = $urandom_range(0, 1) ? QUARTER : -QUARTER;
					q[(pick + 1) % 4] = $urandom_range(0, 1) ? QUARTER : -QUARTER;
				end
			end
		endcase
		for (k = 0; k < 3; k++) begin
			case ($urandom_range(0, 3))
				0: sh[k] = '0;
				1: sh[k] = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
				2: sh[k] = $urandom;
				default: sh[k] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			endcase
		end
		set_pose(q[0], q[1], q[2], q[3], sh[0], sh[1], sh[2]);
	endtask

	initial begin : stimulus
		int seg, k, n;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// identity pose out of reset: field extremes pass straight through
		push_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		push_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000);
		push_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0001, 32'hA5A5_A5A5);
		push_point(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_0000, 32'h5A5A_5A5A);
		drain();

		// quarter turn about z with extreme translation: saturation both ways
		set_pose(QUARTER, 32'h0, 32'h0, QUARTER, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
		push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'h0000_0001);
		push_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0002);
		push_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0000_0003);
		push_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0004);
		drain();

		// components past +-1.0 get clamped; the result is not normalized
		set_pose(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, prt_pkg::QONE,
			32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
		push_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'hDEAD_BEEF);
		push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001);
		push_point(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFE);
		drain();

		// half turn about x: negating the most negative coordinate saturates
		set_pose(32'h0, prt_pkg::QNEG, 32'h0, 32'h0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0);
		push_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0000_0005);
		push_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0006);
		drain();

		// w = -1.0 is the identity rotation as well
		set_pose(prt_pkg::QNEG, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
		push_point(32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9, 32'h0000_0007);

		// random poses and points, three sender pacing modes
		for (seg = 0; seg < SEGMENTS; seg++) begin
			if (seg < 5) begin
				idle_pct = 27;
			end else if (seg < 10) begin
				idle_pct = 56;
			end else begin
				idle_pct = 0;
			end
			drain();
			random_pose();
			for (k = 0; k < SEG_ITEMS; k++) begin
				push_point(pick_coord(), pick_coord(), pick_coord(), $urandom);
				// each cycle idles with the segment's odds
				while ($urandom_range(1, 100) <= idle_pct) begin
					start <= 1'b0;
					@(posedge clk);
				end
			end
		end

		// wind down, bounded
		start <= 1'b0;
		for (n = 0; n < 500; n++) begin
			@(posedge clk);
			if (pending == 0) begin
				break;
			end
		end
		repeat (2 * PIPE_DEPTH) @(posedge clk);
		if (pending != 0) begin
			$display("%0t ns: %0d moved points never came back", $time, pending);
		end

		$display("Moved %0d points under %0d poses; %0d results compared field by field.",
			points_sent, poses, checked);
		$display("Sender pacing ran at 27%% idle, 56%% idle and back to back.");
		if (fail_count == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#3_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
